// ===== rtl/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the circle collision resolver
// Item structs, stored circle record, fixed-point widths and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

  // sizing
  localparam int unsigned MAX_CIRCLES_DEF = 32;
  localparam int unsigned IDX_W           = 6;

  // fixed-point widths of one pair update
  localparam int unsigned DIFF_W     = 17;  // centre / velocity difference
  localparam int unsigned SUMR_W     = 9;   // radius sum
  localparam int unsigned SR2_W      = 18;  // radius sum squared
  localparam int unsigned D2_W       = 34;  // squared distance, any pair
  localparam int unsigned SQ_IN_W    = 34;  // radicand, squared distance in Q.16
  localparam int unsigned DIST_W     = 17;  // distance in Q.8
  localparam int unsigned ABS_W      = 9;   // |dx| of a contacting pair
  localparam int unsigned UNIT_SHIFT = 24;
  localparam int unsigned NUM_W      = ABS_W + UNIT_SHIFT;
  localparam int unsigned QUO_W      = 17;  // |normal| in Q.16, at most one
  localparam int unsigned NRM_W      = 18;  // signed normal component
  localparam int unsigned OV_SHIFT   = 8;
  localparam int unsigned MUL_A_W    = 35;
  localparam int unsigned MUL_B_W    = 18;
  localparam int unsigned PROD_W     = 53;
  localparam int unsigned RVN_W      = 35;
  localparam int unsigned POS_SHIFT  = 25;
  localparam int unsigned VEL_SHIFT  = 32;

  // input item
  typedef struct packed {
    logic signed [15:0] in_pos_x;
    logic signed [15:0] in_pos_y;
    logic        [7:0]  in_radius;
    logic signed [15:0] in_vel_x;
    logic signed [15:0] in_vel_y;
    logic               in_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        [5:0]  out_index;
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic               out_last;
  } out_item_t;

  // one stored circle
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [7:0]  radius;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } circ_t;

  // sign extend a 16-bit value to product width
  function automatic logic signed [PROD_W-1:0] ext16(input logic signed [15:0] v);
    logic signed [PROD_W-1:0] r;
    r = v;
    return r;
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [PROD_W-1:0] trunc_shr(
    input logic signed [PROD_W-1:0] v, input int unsigned sh);
    logic signed [PROD_W-1:0] q;
    logic        [PROD_W-1:0] mask;
    mask = ~({PROD_W{1'b1}} << sh);
    q    = v >>> sh;
    if (v[PROD_W-1] && ((v & mask) != '0)) begin
      q = q + $signed({{(PROD_W-1){1'b0}}, 1'b1});
    end
    return q;
  endfunction

  // saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = $signed({{(PROD_W-15){1'b0}}, 15'h7fff});
    lo = $signed({{(PROD_W-15){1'b1}}, 15'h0000});
    if (v > hi) return 16'sh7fff;
    if (v < lo) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== rtl/ccr_ram.sv =====
// ----------------------------------------------------------------------------
// ccr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ccr_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccr_sqrt: iterative integer square root
// Restoring method, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_sqrt #(
  parameter int unsigned IN_W = ccr_pkg::SQ_IN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IN_W-1:0]     rad,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned REM_W = OUT_W + 2;
  localparam int unsigned CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [OUT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;

  // one root bit per step
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_t    = {rem_r, rad_r[IN_W-1 -: 2]};
    trial    = {{(REM_W-OUT_W){1'b0}}, root_r, 2'b01};
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_t >= trial) begin
        rem_nxt  = REM_W'(rem_t - trial);
        root_nxt = {root_r[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_t);
        root_nxt = {root_r[OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/ccr_div.sv =====
// ----------------------------------------------------------------------------
// ccr_div: iterative unsigned divider
// Restoring long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_div #(
  parameter int unsigned NUM_W = ccr_pkg::NUM_W,
  parameter int unsigned DEN_W = ccr_pkg::DIST_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_t;

  // numerator shifts out at the top, quotient bits shift in below
  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_t    = {rem_r, num_r[NUM_W-1]};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_t >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_t - {1'b0, den_r});
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(rem_t);
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== rtl/circle_collision_resolver.sv =====
// ----------------------------------------------------------------------------
// circle_collision_resolver: pairwise elastic circle collision response
// Loads circles into a RAM, resolves every ordered pair in place with a
// read-modify-write sequencer, then streams the circles back out.
// ----------------------------------------------------------------------------
//   channel | dir | payload     | handshake
//   in_     | in  | in_item_t   | in_valid / in_ready
//   out_    | out | out_item_t  | out_valid / out_ready
//
// A circle that is not last is written to the RAM as it is accepted. The
// last item starts a pass over all n*(n-1) ordered pairs; a pair that
// touches also runs the bit-serial square root and two bit-serial
// divisions of the unit normal.
// Each circle is emitted through S_ERD, S_ELAT and S_EOUT; S_EOUT holds on any out_ready stall.
// No item is accepted during a pass or while results are emitted.
// Reset is synchronous and active low; the RAM needs no clearing.
`timescale 1ns / 1ps

module circle_collision_resolver #(
  parameter int unsigned MAX_CIRCLES = ccr_pkg::MAX_CIRCLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccr_pkg::out_item_t out_data
);

  localparam int unsigned AW         = $clog2(MAX_CIRCLES);
  localparam int unsigned CW         = $clog2(MAX_CIRCLES + 1);
  localparam int unsigned IDX_W      = ccr_pkg::IDX_W;
  localparam int unsigned DIFF_W     = ccr_pkg::DIFF_W;
  localparam int unsigned SUMR_W     = ccr_pkg::SUMR_W;
  localparam int unsigned SR2_W      = ccr_pkg::SR2_W;
  localparam int unsigned D2_W       = ccr_pkg::D2_W;
  localparam int unsigned SQ_IN_W    = ccr_pkg::SQ_IN_W;
  localparam int unsigned DIST_W     = ccr_pkg::DIST_W;
  localparam int unsigned ABS_W      = ccr_pkg::ABS_W;
  localparam int unsigned UNIT_SHIFT = ccr_pkg::UNIT_SHIFT;
  localparam int unsigned NUM_W      = ccr_pkg::NUM_W;
  localparam int unsigned QUO_W      = ccr_pkg::QUO_W;
  localparam int unsigned NRM_W      = ccr_pkg::NRM_W;
  localparam int unsigned OV_SHIFT   = ccr_pkg::OV_SHIFT;
  localparam int unsigned MUL_A_W    = ccr_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W    = ccr_pkg::MUL_B_W;
  localparam int unsigned PROD_W     = ccr_pkg::PROD_W;
  localparam int unsigned RVN_W      = ccr_pkg::RVN_W;
  localparam int unsigned POS_SHIFT  = ccr_pkg::POS_SHIFT;
  localparam int unsigned VEL_SHIFT  = ccr_pkg::VEL_SHIFT;
  localparam int unsigned CIRC_W     = $bits(ccr_pkg::circ_t);

  typedef enum logic [24:0] {
    S_LOAD = 25'h0000001,
    S_NEXT = 25'h0000002,
    S_RDI  = 25'h0000004,
    S_RDJ  = 25'h0000008,
    S_CAPJ = 25'h0000010,
    S_MSR  = 25'h0000020,
    S_MDX  = 25'h0000040,
    S_MDY  = 25'h0000080,
    S_CMP  = 25'h0000100,
    S_SQRT = 25'h0000200,
    S_DIVX = 25'h0000400,
    S_DIVY = 25'h0000800,
    S_MPX  = 25'h0001000,
    S_MPY  = 25'h0002000,
    S_MVX  = 25'h0004000,
    S_MVY  = 25'h0008000,
    S_RVN  = 25'h0010000,
    S_MTX  = 25'h0020000,
    S_MTY  = 25'h0040000,
    S_TY   = 25'h0080000,
    S_WRI  = 25'h0100000,
    S_WRJ  = 25'h0200000,
    S_ERD  = 25'h0400000,
    S_ELAT = 25'h0800000,
    S_EOUT = 25'h1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  ccr_pkg::circ_t            ci_r, ci_nxt;
  ccr_pkg::circ_t            cj_r, cj_nxt;
  logic signed [DIFF_W-1:0]  dx_r, dx_nxt;
  logic signed [DIFF_W-1:0]  dy_r, dy_nxt;
  logic [SUMR_W-1:0]         sr_r, sr_nxt;
  logic [SR2_W-1:0]          sr2_r, sr2_nxt;
  logic [D2_W-1:0]           d2_r, d2_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;
  logic signed [NRM_W-1:0]   nx_r, nx_nxt;
  logic signed [NRM_W-1:0]   ny_r, ny_nxt;
  logic signed [RVN_W-1:0]   rvn_r, rvn_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r, out_valid_nxt;
  ccr_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  ccr_pkg::circ_t            ram_wdata;
  logic [AW-1:0]             ram_raddr;
  ccr_pkg::circ_t            ram_rdata;
  logic [CIRC_W-1:0]         ram_rdata_raw;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic                      sq_start;
  logic [SQ_IN_W-1:0]        sq_in;
  logic                      sq_done;
  logic [DIST_W-1:0]         sq_root;
  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DIST_W-1:0]         div_den;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;

  logic [CW-1:0]             count_inc;
  logic [D2_W-1:0]           d2_sum;
  logic signed [RVN_W-1:0]   rvn_sum;
  logic [DIFF_W-1:0]         dx_abs;
  logic [DIFF_W-1:0]         dy_abs;
  logic signed [NRM_W-1:0]   quo_s;
  logic signed [NRM_W-1:0]   ov;
  logic signed [DIFF_W-1:0]  dvx;
  logic signed [DIFF_W-1:0]  dvy;
  logic signed [PROD_W-1:0]  tv;

  // state memory
  ccr_ram #(
    .WIDTH (CIRC_W),
    .DEPTH (MAX_CIRCLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );
  assign ram_rdata = ram_rdata_raw;

  // distance unit
  ccr_sqrt #(
    .IN_W (SQ_IN_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  // normal divider, shared by both components
  ccr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIST_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared datapath terms
  assign dx_abs = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign dy_abs = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
  assign quo_s  = $signed({1'b0, div_quot[QUO_W-1:0]});
  assign ov     = $signed({1'b0, DIST_W'({sr_r, {OV_SHIFT{1'b0}}} - dist_r)});
  assign dvx    = DIFF_W'(cj_r.vel_x) - DIFF_W'(ci_r.vel_x);
  assign dvy    = DIFF_W'(cj_r.vel_y) - DIFF_W'(ci_r.vel_y);
  assign tv     = ccr_pkg::trunc_shr(prod_r, VEL_SHIFT);
  assign d2_sum = d2_r + prod_r[D2_W-1:0];
  assign rvn_sum = rvn_r + prod_r[RVN_W-1:0];
  assign in_ready = (state_r == S_LOAD);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sr_nxt        = sr_r;
    sr2_nxt       = sr2_r;
    d2_nxt        = d2_r;
    dist_nxt      = dist_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    rvn_nxt       = rvn_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r[AW-1:0];
    ram_wdata     = ci_r;
    ram_raddr     = i_r[AW-1:0];
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;
    sq_in         = {d2_sum[SR2_W-1:0], {(SQ_IN_W-SR2_W){1'b0}}};
    div_start     = 1'b0;
    div_num       = {dx_abs[ABS_W-1:0], {UNIT_SHIFT{1'b0}}};
    div_den       = dist_r;
    count_inc     = count_r;

    unique case (state_r)
      // load one circle per item
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < CW'(MAX_CIRCLES)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = '{pos_x:  in_data.in_pos_x,
                          pos_y:  in_data.in_pos_y,
                          radius: in_data.in_radius,
                          vel_x:  in_data.in_vel_x,
                          vel_y:  in_data.in_vel_y};
            count_inc = count_r + 1'b1;
          end
          count_nxt = count_inc;
          if (in_data.in_last) begin
            n_nxt     = count_inc;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_NEXT;
          end
        end
      end
      // walk ordered pairs, i outer
      S_NEXT: begin
        if (i_r == n_r) begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else if (j_r == n_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        ram_raddr = i_r[AW-1:0];
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        ram_raddr = j_r[AW-1:0];
        ci_nxt    = ram_rdata;
        state_nxt = S_CAPJ;
      end
      // differences and radius sum
      S_CAPJ: begin
        cj_nxt    = ram_rdata;
        dx_nxt    = DIFF_W'(ram_rdata.pos_x) - DIFF_W'(ci_r.pos_x);
        dy_nxt    = DIFF_W'(ram_rdata.pos_y) - DIFF_W'(ci_r.pos_y);
        sr_nxt    = SUMR_W'(ram_rdata.radius) + SUMR_W'(ci_r.radius);
        state_nxt = S_MSR;
      end
      S_MSR: begin
        mul_a     = MUL_A_W'($signed({1'b0, sr_r}));
        mul_b     = MUL_B_W'($signed({1'b0, sr_r}));
        state_nxt = S_MDX;
      end
      S_MDX: begin
        sr2_nxt   = prod_r[SR2_W-1:0];
        mul_a     = MUL_A_W'(dx_r);
        mul_b     = MUL_B_W'(dx_r);
        state_nxt = S_MDY;
      end
      S_MDY: begin
        d2_nxt    = prod_r[D2_W-1:0];
        mul_a     = MUL_A_W'(dy_r);
        mul_b     = MUL_B_W'(dy_r);
        state_nxt = S_CMP;
      end
      // contact test, coincident centres skipped
      S_CMP: begin
        if ((d2_sum == '0) || (D2_W'(sr2_r) < d2_sum)) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_NEXT;
        end else begin
          sq_start  = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          dist_nxt  = sq_root;
          div_start = 1'b1;
          div_den   = sq_root;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          nx_nxt    = dx_r[DIFF_W-1] ? NRM_W'(-quo_s) : quo_s;
          div_start = 1'b1;
          div_num   = {dy_abs[ABS_W-1:0], {UNIT_SHIFT{1'b0}}};
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          ny_nxt    = dy_r[DIFF_W-1] ? NRM_W'(-quo_s) : quo_s;
          state_nxt = S_MPX;
        end
      end
      // push apart by half the overlap
      S_MPX: begin
        mul_a     = MUL_A_W'(ov);
        mul_b     = nx_r;
        state_nxt = S_MPY;
      end
      S_MPY: begin
        ci_nxt.pos_x = ccr_pkg::sat16(ccr_pkg::trunc_shr(
                         (ccr_pkg::ext16(ci_r.pos_x) <<< POS_SHIFT) - prod_r, POS_SHIFT));
        cj_nxt.pos_x = ccr_pkg::sat16(ccr_pkg::trunc_shr(
                         (ccr_pkg::ext16(cj_r.pos_x) <<< POS_SHIFT) + prod_r, POS_SHIFT));
        mul_a     = MUL_A_W'(ov);
        mul_b     = ny_r;
        state_nxt = S_MVX;
      end
      S_MVX: begin
        ci_nxt.pos_y = ccr_pkg::sat16(ccr_pkg::trunc_shr(
                         (ccr_pkg::ext16(ci_r.pos_y) <<< POS_SHIFT) - prod_r, POS_SHIFT));
        cj_nxt.pos_y = ccr_pkg::sat16(ccr_pkg::trunc_shr(
                         (ccr_pkg::ext16(cj_r.pos_y) <<< POS_SHIFT) + prod_r, POS_SHIFT));
        mul_a     = MUL_A_W'(dvx);
        mul_b     = nx_r;
        state_nxt = S_MVY;
      end
      // relative normal speed
      S_MVY: begin
        rvn_nxt   = prod_r[RVN_W-1:0];
        mul_a     = MUL_A_W'(dvy);
        mul_b     = ny_r;
        state_nxt = S_RVN;
      end
      S_RVN: begin
        rvn_nxt = rvn_sum;
        if (rvn_sum[RVN_W-1]) begin
          state_nxt = S_MTX;
        end else begin
          state_nxt = S_WRI;
        end
      end
      // swap normal velocity components
      S_MTX: begin
        mul_a     = MUL_A_W'(rvn_r);
        mul_b     = nx_r;
        state_nxt = S_MTY;
      end
      S_MTY: begin
        ci_nxt.vel_x = ccr_pkg::sat16(ccr_pkg::ext16(ci_r.vel_x) + tv);
        cj_nxt.vel_x = ccr_pkg::sat16(ccr_pkg::ext16(cj_r.vel_x) - tv);
        mul_a     = MUL_A_W'(rvn_r);
        mul_b     = ny_r;
        state_nxt = S_TY;
      end
      S_TY: begin
        ci_nxt.vel_y = ccr_pkg::sat16(ccr_pkg::ext16(ci_r.vel_y) + tv);
        cj_nxt.vel_y = ccr_pkg::sat16(ccr_pkg::ext16(cj_r.vel_y) - tv);
        state_nxt = S_WRI;
      end
      // write the pair back
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = ci_r;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = cj_r;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_NEXT;
      end
      // emit circles in load order
      S_ERD: begin
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_ELAT;
      end
      S_ELAT: begin
        out_data_nxt  = '{out_index: IDX_W'(k_r),
                          out_pos_x: ram_rdata.pos_x,
                          out_pos_y: ram_rdata.pos_y,
                          out_vel_x: ram_rdata.vel_x,
                          out_vel_y: ram_rdata.vel_y,
                          out_last:  ((k_r + 1'b1) == n_r)};
        out_valid_nxt = 1'b1;
        state_nxt     = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if ((k_r + 1'b1) == n_r) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers and shared multiplier
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    ci_r       <= ci_nxt;
    cj_r       <= cj_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sr_r       <= sr_nxt;
    sr2_r      <= sr2_nxt;
    d2_r       <= d2_nxt;
    dist_r     <= dist_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    rvn_r      <= rvn_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= mul_a * mul_b;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ccr_checker.sv =====
// ----------------------------------------------------------------------------
// ccr_checker: port-level checks of the circle collision resolver
// Watches the handshakes and the load / emit phasing over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ccr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ccr_pkg::out_item_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // loading and emitting never overlap
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // the last item closes loading
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.in_last |=> !in_ready)
    else $error("input still ready after last item");

  // nothing follows the final result at once
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.out_last |=> !out_valid)
    else $error("result after the final one");

endmodule

bind circle_collision_resolver ccr_checker u_ccr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
